// ===== hdl/bdqs_pkg.sv =====
// Package for the bounded deque with search: sizes, command and status codes,
// the store write-port type and the circular slot helper. No dependencies.
`default_nettype none
package bdqs_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 3;
	localparam int STS_W    = 2;
	localparam int POS_W    = 4;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd4;

	localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [VAL_W-1:0] data;
	} bdqs_wr_t;

	// store slot of the entry at a given offset from the front
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, front} + {1'b0, off};
		if (sum >= (CNT_W + 1)'(CAPACITY)) begin
			sum = sum - (CNT_W + 1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/bdqs_store.sv =====
// Value store of the deque: one write port, one registered read port.
// Depends on bdqs_pkg for sizes and the write-port type.
`default_nettype none
module bdqs_store (
	input  wire logic                      clk,
	input  wire bdqs_pkg::bdqs_wr_t        wr,
	input  wire logic [bdqs_pkg::IDX_W-1:0] raddr,
	output logic [bdqs_pkg::VAL_W-1:0]     rdata
);

	logic [bdqs_pkg::VAL_W-1:0] mem_q [bdqs_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/bounded_deque_with_search.sv =====
// Bounded deque of signed 32-bit words with a front-to-back linear search.
// Inserts, removals, unknown words and searches of an empty list: result in the cycle after acceptance.
// Search: one read prime, then one compare per cycle; busy holds until it answers,
// on the first hit, or on a miss once the last entry has been compared.
// Results are shown for one cycle on done and cannot be stalled.
// Reset (arst_n low, asynchronous) empties the list; store contents are not cleared.
`default_nettype none
module bounded_deque_with_search (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [bdqs_pkg::CMD_W-1:0]   command,
	input  wire logic signed [bdqs_pkg::VAL_W-1:0] value,
	output logic                              done,
	output logic [bdqs_pkg::STS_W-1:0]        status,
	output logic                              found,
	output logic [bdqs_pkg::POS_W-1:0]        position,
	output logic [bdqs_pkg::CNT_W-1:0]        count,
	output logic                              is_empty
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic                          state_q;
	logic [bdqs_pkg::IDX_W-1:0]    front_q;
	logic [bdqs_pkg::CNT_W-1:0]    cnt_q;
	logic [bdqs_pkg::VAL_W-1:0]    key_q;
	logic [bdqs_pkg::CNT_W-1:0]    rd_off_q;
	logic [bdqs_pkg::CNT_W-1:0]    cmp_off_q;
	logic                          cmp_vld_q;

	logic                          done_q;
	logic [bdqs_pkg::STS_W-1:0]    status_q;
	logic                          found_q;
	logic [bdqs_pkg::POS_W-1:0]    position_q;

	logic                          accept;
	logic                          full;
	logic                          empty;
	logic [bdqs_pkg::IDX_W-1:0]    front_dec;
	logic [bdqs_pkg::IDX_W-1:0]    front_inc;
	logic [bdqs_pkg::VAL_W-1:0]    rdata;
	logic                          hit;
	logic                          last;
	bdqs_pkg::bdqs_wr_t            wr;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (cnt_q >= bdqs_pkg::CNT_FULL);
	assign empty  = (cnt_q == '0);

	assign front_dec = (front_q == '0) ? bdqs_pkg::IDX_LAST : front_q - 1'b1;
	assign front_inc = (front_q == bdqs_pkg::IDX_LAST) ? '0 : front_q + 1'b1;

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = bdqs_pkg::slot_of(front_q, cnt_q);
		wr.data = value;
		if (accept && !full) begin
			if (command == bdqs_pkg::CMD_INS_FRONT) begin
				wr.en   = 1'b1;
				wr.addr = front_dec;
			end else if (command == bdqs_pkg::CMD_INS_BACK) begin
				wr.en   = 1'b1;
			end
		end
	end

	bdqs_store u_store (
		.clk   (clk),
		.wr    (wr),
		.raddr (bdqs_pkg::slot_of(front_q, rd_off_q)),
		.rdata (rdata)
	);

	assign hit  = cmp_vld_q && (rdata == key_q);
	assign last = cmp_vld_q && (cmp_off_q == cnt_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			front_q    <= '0;
			cnt_q      <= '0;
			key_q      <= '0;
			cmp_vld_q  <= 1'b0;
			rd_off_q   <= '0;
			cmp_off_q  <= '0;
			done_q     <= 1'b0;
			status_q   <= bdqs_pkg::STS_DONE;
			found_q    <= 1'b0;
			position_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q   <= bdqs_pkg::STS_DONE;
						found_q    <= 1'b0;
						position_q <= '0;
						key_q      <= value;
						rd_off_q   <= '0;
						cmp_off_q  <= '0;
						cmp_vld_q  <= 1'b0;
						done_q     <= 1'b1;
						unique case (command)
							bdqs_pkg::CMD_INS_FRONT: begin
								if (full) begin
									status_q <= bdqs_pkg::STS_FULL;
								end else begin
									front_q <= front_dec;
									cnt_q   <= cnt_q + 1'b1;
								end
							end
							bdqs_pkg::CMD_INS_BACK: begin
								if (full) begin
									status_q <= bdqs_pkg::STS_FULL;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							bdqs_pkg::CMD_REM_FRONT: begin
								if (empty) begin
									status_q <= bdqs_pkg::STS_EMPTY;
								end else begin
									front_q <= front_inc;
									cnt_q   <= cnt_q - 1'b1;
								end
							end
							bdqs_pkg::CMD_REM_BACK: begin
								if (empty) begin
									status_q <= bdqs_pkg::STS_EMPTY;
								end else begin
									cnt_q <= cnt_q - 1'b1;
								end
							end
							bdqs_pkg::CMD_SEARCH: begin
								// an empty list answers at once
								if (!empty) begin
									done_q  <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q    <= 1'b1;
						position_q <= cmp_off_q[bdqs_pkg::POS_W-1:0];
						done_q     <= 1'b1;
						cmp_vld_q  <= 1'b0;
						state_q    <= S_IDLE;
					end else if (last) begin
						done_q    <= 1'b1;
						cmp_vld_q <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						// compare next cycle the word read now
						cmp_vld_q <= 1'b1;
						cmp_off_q <= rd_off_q;
						rd_off_q  <= rd_off_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign found    = found_q;
	assign position = position_q;
	assign count    = cnt_q;
	assign is_empty = empty;

endmodule
`default_nettype wire
